FILE: src/pks_pkg.sv
// Shared types and constants of the pose Kalman smoother.
package pks_pkg;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] quat_x;
    logic [31:0] quat_y;
    logic [31:0] quat_z;
    logic [31:0] quat_w;
    logic [31:0] track_error;
    logic        seen;
    logic [7:0]  port_tag;
  } sample_t;

  typedef struct packed {
    logic [31:0] est_x;
    logic [31:0] est_y;
    logic [31:0] est_z;
    logic [31:0] est_qx;
    logic [31:0] est_qy;
    logic [31:0] est_qz;
    logic [31:0] est_qw;
    logic [31:0] out_error;
    logic        out_seen;
    logic [7:0]  out_port;
  } pose_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEED_VISIBLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_MEAS_VAR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_MEAS_VAR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_PROC_VAR    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_PROC_VAR = 3'd6;

  localparam logic [31:0] RST_ERROR_LIMIT     = 32'd327680;
  localparam logic [47:0] RST_POS_MEAS_VAR    = 48'd2275285382;
  localparam logic [47:0] RST_ORIENT_MEAS_VAR = 48'd865941;
  localparam logic [47:0] RST_POS_PROC_VAR    = 48'd10995116278;
  localparam logic [47:0] RST_ORIENT_PROC_VAR = 48'd1099512;

  localparam logic [30:0] GAIN_ONE   = 31'h4000_0000;
  localparam logic [31:0] QUAT_ONE   = 32'h4000_0000;
  localparam logic [5:0]  GAIN_STEPS = 6'd30;
  localparam logic [5:0]  WORD_STEPS = 6'd32;

  // Magnitude of a two's complement word; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

FILE: src/pks_if.sv
// Valid/ready channels carrying tracker samples in and filtered poses out.
interface pks_sample_if;
  logic              valid;
  logic              ready;
  pks_pkg::sample_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pks_pose_if;
  logic            valid;
  logic            ready;
  pks_pkg::pose_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/pose_kalman_smoother.sv
// Pose Kalman smoother: gated scalar Kalman filters for tracker position and orientation.
//
// A sample arrives on the sample channel and is taken only while the block is idle.
// A sample that fails the gate (filter disabled, not visible while visibility is
// required, or error above a non-zero limit) is consumed on acceptance and yields no
// transaction on the pose channel. A passing sample runs both filter steps and two
// quaternion normalizations (three for the first sample after reset) on one bit-serial
// compare/subtract unit (divider and square root) and one 33x32 multiplier, both under
// a small sequencer. The first passing sample after reset also seeds the orientation.
// The result sits in an output register; a stalled receiver holds it there, and the
// next sample may be accepted meanwhile, but a finished result waits until the
// register is free. Reset restores the register defaults and clears the estimates,
// variances and the seeded flag. Configuration is written through cfg_write,
// cfg_index and cfg_data; the user must write it only while the block is idle, and
// the block itself does not enforce this. Indexes beyond the list are ignored.
module pose_kalman_smoother (
  input  logic                              clk,
  input  logic                              rst,
  pks_sample_if.sink                        sample,
  pks_pose_if.source                        pose,
  input  logic                              cfg_write,
  input  logic [pks_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pks_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [21:0] {
    S_IDLE     = 22'h000001,
    S_DISPATCH = 22'h000002,
    S_KPRED    = 22'h000004,
    S_KDEN     = 22'h000008,
    S_DIV      = 22'h000010,
    S_KMHI     = 22'h000020,
    S_KMLO     = 22'h000040,
    S_KUPD     = 22'h000080,
    S_BMUL     = 22'h000100,
    S_BADD     = 22'h000200,
    S_NLOAD    = 22'h000400,
    S_NCHK     = 22'h000800,
    S_NSHIFT   = 22'h001000,
    S_NSQM     = 22'h002000,
    S_NSQA     = 22'h004000,
    S_SQRT     = 22'h008000,
    S_NDSET    = 22'h010000,
    S_NDEND    = 22'h020000,
    S_DMUL     = 22'h040000,
    S_DACC     = 22'h080000,
    S_FLIP     = 22'h100000,
    S_OUT      = 22'h200000
  } state_t;

  typedef enum logic [8:0] {
    PH_SEED = 9'h001,
    PH_KPOS = 9'h002,
    PH_BPOS = 9'h004,
    PH_KQ   = 9'h008,
    PH_NQ   = 9'h010,
    PH_DOT  = 9'h020,
    PH_BQ   = 9'h040,
    PH_NT   = 9'h080,
    PH_DONE = 9'h100
  } phase_t;

  function automatic phase_t phase_after(input phase_t p);
    case (p)
      PH_SEED: phase_after = PH_KPOS;
      PH_KPOS: phase_after = PH_BPOS;
      PH_BPOS: phase_after = PH_KQ;
      PH_KQ:   phase_after = PH_NQ;
      PH_NQ:   phase_after = PH_DOT;
      PH_DOT:  phase_after = PH_BQ;
      PH_BQ:   phase_after = PH_NT;
      PH_NT:   phase_after = PH_DONE;
      default: phase_after = PH_DONE;
    endcase
  endfunction

  state_t state;
  phase_t phase;

  // Configuration registers.
  logic        filter_enable;
  logic        need_visible;
  logic [31:0] error_limit;
  logic [47:0] pos_meas_var;
  logic [47:0] orient_meas_var;
  logic [47:0] pos_proc_var;
  logic [47:0] orient_proc_var;

  // Filter state.
  logic [31:0] pe [3];
  logic [31:0] qe [4];
  logic [47:0] pvar;
  logic [47:0] qvar;
  logic        seeded;

  // Captured sample and working registers.
  logic [31:0] zp [3];
  logic [31:0] zq [4];
  logic [31:0] nres [4];
  logic [31:0] err_r;
  logic        seen_r;
  logic [7:0]  port_r;

  logic [1:0]  idx;
  logic [5:0]  cnt;
  logic [47:0] pp;
  logic [30:0] k;
  logic [54:0] hi_keep;
  logic [48:0] drem;
  logic [48:0] dden;
  logic [31:0] dlow;
  logic [31:0] dq;
  logic [31:0] na [4];
  logic [3:0]  nsg;
  logic [63:0] s;
  logic [33:0] srem;
  logic [31:0] root;
  logic [66:0] dot;
  logic [64:0] prod;

  logic          out_valid;
  pks_pkg::pose_t out_data;

  // Combinational helpers.
  logic        kq;
  logic [47:0] p_cur, q_cur, r_cur;
  logic [48:0] pred_sum, den_sum;
  logic [30:0] f;
  logic [31:0] bx, bz;
  logic [32:0] bd, bmag;
  logic        bneg;
  logic [65:0] bround;
  logic [36:0] bx_ext, bm_ext, bres;
  logic [31:0] nsrc [4];
  logic        all_small;
  logic [9:0]  sumsq;
  logic        any_top;
  logic [61:0] nnum;
  logic [49:0] dt;
  logic [35:0] st;
  logic [49:0] sa, sb;
  logic [50:0] sdiff;
  logic        sge;
  logic [31:0] dq_next;
  logic [32:0] ma;
  logic [31:0] mb;
  logic        dsign;
  logic [55:0] lo_sum;
  logic [55:0] newp;
  logic        gate;
  logic [31:0] nval;

  assign sample.ready = (state == S_IDLE);
  assign pose.valid   = out_valid;
  assign pose.data    = out_data;

  always_comb begin
    kq       = (phase == PH_KQ);
    p_cur    = kq ? qvar : pvar;
    q_cur    = kq ? orient_proc_var : pos_proc_var;
    r_cur    = kq ? orient_meas_var : pos_meas_var;
    pred_sum = {1'b0, p_cur} + {1'b0, q_cur};
    den_sum  = {1'b0, pp} + {1'b0, r_cur};
    f        = pks_pkg::GAIN_ONE - k;

    // Blend operands: position against the sample, or orientation against nres.
    bx = qe[idx];
    bz = nres[idx];
    if (phase == PH_BPOS) begin
      case (idx)
        2'd0:    begin bx = pe[0]; bz = zp[0]; end
        2'd1:    begin bx = pe[1]; bz = zp[1]; end
        default: begin bx = pe[2]; bz = zp[2]; end
      endcase
    end
    bd     = {bz[31], bz} - {bx[31], bx};
    bneg   = bd[32];
    bmag   = bneg ? (~bd + 33'd1) : bd;
    bround = {1'b0, prod} + 66'(1 << 29);
    bx_ext = {{5{bx[31]}}, bx};
    bm_ext = {1'b0, bround[65:30]};
    bres   = bneg ? (bx_ext - bm_ext) : (bx_ext + bm_ext);

    for (int i = 0; i < 4; i++) begin
      nsrc[i] = (phase == PH_NT) ? nres[i] : zq[i];
    end

    all_small = 1'b1;
    sumsq     = '0;
    any_top   = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (na[i] > 32'd10) all_small = 1'b0;
      sumsq   = sumsq + 10'(na[i][3:0] * na[i][3:0]);
      any_top = any_top | (|na[i][31:29]);
    end

    nnum = {1'b0, na[idx], 29'b0} + {31'b0, root[31:1]};

    // One compare/subtract unit serves the divider and the square root.
    dt = {drem, dlow[31]};
    st = {srem, s[63:62]};
    if (state == S_SQRT) begin
      sa = 50'(st);
      sb = 50'({root, 2'b01});
    end else begin
      sa = dt;
      sb = {1'b0, dden};
    end
    sdiff   = {1'b0, sa} - {1'b0, sb};
    sge     = ~sdiff[50];
    dq_next = {dq[30:0], sge};

    dsign = qe[idx][31] ^ nres[idx][31];
    case (state)
      S_KMHI: begin ma = 33'(pp[47:24]); mb = 32'(f); end
      S_KMLO: begin ma = 33'(pp[23:0]);  mb = 32'(f); end
      S_BMUL: begin ma = bmag;           mb = 32'(k); end
      S_NSQM: begin ma = 33'(na[idx]);   mb = na[idx]; end
      S_DMUL: begin
        ma = 33'(pks_pkg::mag32(qe[idx]));
        mb = pks_pkg::mag32(nres[idx]);
      end
      default: begin ma = '0; mb = '0; end
    endcase

    lo_sum = {26'b0, hi_keep[5:0], 24'b0} + {1'b0, prod[54:0]};
    newp   = {7'b0, hi_keep[54:6]} + {30'b0, lo_sum[55:30]};

    gate = filter_enable && (!need_visible || sample.data.seen) &&
           !((error_limit != 32'd0) && (sample.data.track_error > error_limit));

    nval = nsg[idx] ? (~dq + 32'd1) : dq;
  end

  always_ff @(posedge clk) begin
    prod <= 65'(ma) * 65'(mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= PH_DONE;
      filter_enable   <= 1'b1;
      need_visible    <= 1'b1;
      error_limit     <= pks_pkg::RST_ERROR_LIMIT;
      pos_meas_var    <= pks_pkg::RST_POS_MEAS_VAR;
      orient_meas_var <= pks_pkg::RST_ORIENT_MEAS_VAR;
      pos_proc_var    <= pks_pkg::RST_POS_PROC_VAR;
      orient_proc_var <= pks_pkg::RST_ORIENT_PROC_VAR;
      for (int i = 0; i < 3; i++) pe[i] <= '0;
      for (int i = 0; i < 4; i++) qe[i] <= '0;
      pvar      <= '0;
      qvar      <= '0;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          pks_pkg::CFG_FILTER_ENABLE:   filter_enable   <= cfg_data[0];
          pks_pkg::CFG_NEED_VISIBLE:    need_visible    <= cfg_data[0];
          pks_pkg::CFG_ERROR_LIMIT:     error_limit     <= cfg_data[31:0];
          pks_pkg::CFG_POS_MEAS_VAR:    pos_meas_var    <= cfg_data;
          pks_pkg::CFG_ORIENT_MEAS_VAR: orient_meas_var <= cfg_data;
          pks_pkg::CFG_POS_PROC_VAR:    pos_proc_var    <= cfg_data;
          pks_pkg::CFG_ORIENT_PROC_VAR: orient_proc_var <= cfg_data;
          default: ;
        endcase
      end

      // In S_OUT a ready receiver always gets the next result loaded below.
      if (pose.ready && state != S_OUT) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            zp[0]  <= sample.data.pos_x;
            zp[1]  <= sample.data.pos_y;
            zp[2]  <= sample.data.pos_z;
            zq[0]  <= sample.data.quat_x;
            zq[1]  <= sample.data.quat_y;
            zq[2]  <= sample.data.quat_z;
            zq[3]  <= sample.data.quat_w;
            err_r  <= sample.data.track_error;
            seen_r <= sample.data.seen;
            port_r <= sample.data.port_tag;
            if (gate) begin
              state <= S_DISPATCH;
              if (!seeded) begin
                phase  <= PH_SEED;
                pe[0]  <= sample.data.pos_x;
                pe[1]  <= sample.data.pos_y;
                pe[2]  <= sample.data.pos_z;
                pvar   <= pos_meas_var;
                qvar   <= orient_meas_var;
                seeded <= 1'b1;
              end else begin
                phase <= PH_KPOS;
              end
            end
          end
        end

        S_DISPATCH: begin
          idx <= 2'd0;
          case (phase)
            PH_KPOS, PH_KQ:         state <= S_KPRED;
            PH_BPOS, PH_BQ:         state <= S_BMUL;
            PH_SEED, PH_NQ, PH_NT:  state <= S_NLOAD;
            PH_DOT: begin
              dot   <= '0;
              state <= S_DMUL;
            end
            default:                state <= S_OUT;
          endcase
        end

        S_KPRED: begin
          pp    <= pred_sum[48] ? 48'hFFFF_FFFF_FFFF : pred_sum[47:0];
          state <= S_KDEN;
        end

        S_KDEN: begin
          if (r_cur == 48'd0) begin
            // With no measurement noise the gain is one, or zero if p is zero too.
            k     <= (pp == 48'd0) ? 31'd0 : pks_pkg::GAIN_ONE;
            state <= S_KMHI;
          end else begin
            drem  <= {1'b0, pp};
            dlow  <= '0;
            dden  <= den_sum;
            dq    <= '0;
            cnt   <= pks_pkg::GAIN_STEPS;
            state <= S_DIV;
          end
        end

        S_DIV: begin
          drem <= sge ? sdiff[48:0] : dt[48:0];
          dlow <= {dlow[30:0], 1'b0};
          dq   <= dq_next;
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            if (phase == PH_KPOS || phase == PH_KQ) begin
              k     <= dq_next[30:0];
              state <= S_KMHI;
            end else begin
              state <= S_NDEND;
            end
          end
        end

        S_KMHI: state <= S_KMLO;

        S_KMLO: begin
          hi_keep <= prod[54:0];
          state   <= S_KUPD;
        end

        S_KUPD: begin
          if (kq) qvar <= newp[47:0];
          else    pvar <= newp[47:0];
          phase <= phase_after(phase);
          state <= S_DISPATCH;
        end

        S_BMUL: state <= S_BADD;

        S_BADD: begin
          if (phase == PH_BPOS) begin
            case (idx)
              2'd0:    pe[0] <= bres[31:0];
              2'd1:    pe[1] <= bres[31:0];
              default: pe[2] <= bres[31:0];
            endcase
          end else begin
            nres[idx] <= bres[31:0];
          end
          idx <= idx + 2'd1;
          if ((phase == PH_BPOS && idx == 2'd2) || idx == 2'd3) begin
            phase <= phase_after(phase);
            state <= S_DISPATCH;
          end else begin
            state <= S_BMUL;
          end
        end

        S_NLOAD: begin
          for (int i = 0; i < 4; i++) begin
            na[i]  <= pks_pkg::mag32(nsrc[i]);
            nsg[i] <= nsrc[i][31];
          end
          state <= S_NCHK;
        end

        S_NCHK: begin
          if (all_small && sumsq <= 10'd115) begin
            // A near-zero quaternion becomes the identity.
            for (int i = 0; i < 3; i++) begin
              if (phase == PH_NQ) nres[i] <= '0;
              else                qe[i]   <= '0;
            end
            if (phase == PH_NQ) nres[3] <= pks_pkg::QUAT_ONE;
            else                qe[3]   <= pks_pkg::QUAT_ONE;
            phase <= phase_after(phase);
            state <= S_DISPATCH;
          end else begin
            state <= S_NSHIFT;
          end
        end

        S_NSHIFT: begin
          if (any_top) begin
            idx   <= 2'd0;
            s     <= '0;
            state <= S_NSQM;
          end else begin
            for (int i = 0; i < 4; i++) na[i] <= {na[i][30:0], 1'b0};
          end
        end

        S_NSQM: state <= S_NSQA;

        S_NSQA: begin
          s   <= s + {2'b0, prod[63:2]};
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            srem  <= '0;
            root  <= '0;
            cnt   <= pks_pkg::WORD_STEPS;
            state <= S_SQRT;
          end else begin
            state <= S_NSQM;
          end
        end

        S_SQRT: begin
          srem <= sge ? sdiff[33:0] : st[33:0];
          root <= {root[30:0], sge};
          s    <= {s[61:0], 2'b0};
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            idx   <= 2'd0;
            state <= S_NDSET;
          end
        end

        S_NDSET: begin
          drem  <= {19'b0, nnum[61:32]};
          dlow  <= nnum[31:0];
          dden  <= {17'b0, root};
          dq    <= '0;
          cnt   <= pks_pkg::WORD_STEPS;
          state <= S_DIV;
        end

        S_NDEND: begin
          if (phase == PH_NQ) nres[idx] <= nval;
          else                qe[idx]   <= nval;
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            phase <= phase_after(phase);
            state <= S_DISPATCH;
          end else begin
            state <= S_NDSET;
          end
        end

        S_DMUL: state <= S_DACC;

        S_DACC: begin
          dot <= dsign ? (dot - 67'(prod)) : (dot + 67'(prod));
          idx <= idx + 2'd1;
          state <= (idx == 2'd3) ? S_FLIP : S_DMUL;
        end

        S_FLIP: begin
          // Take the measurement on the same hemisphere as the estimate.
          if (dot[66]) begin
            for (int i = 0; i < 4; i++) nres[i] <= ~nres[i] + 32'd1;
          end
          phase <= phase_after(phase);
          state <= S_DISPATCH;
        end

        S_OUT: begin
          if (!out_valid || pose.ready) begin
            out_valid          <= 1'b1;
            out_data.est_x     <= pe[0];
            out_data.est_y     <= pe[1];
            out_data.est_z     <= pe[2];
            out_data.est_qx    <= qe[0];
            out_data.est_qy    <= qe[1];
            out_data.est_qz    <= qe[2];
            out_data.est_qw    <= qe[3];
            out_data.out_error <= err_r;
            out_data.out_seen  <= seen_r;
            out_data.out_port  <= port_r;
            state              <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the pose Kalman smoother: gated samples in, filtered poses out.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint quat4_t [4];

  localparam longint unsigned VAR_MAX = 64'hFFFF_FFFF_FFFF;
  localparam int unsigned TIMEOUT_CYCLES = 6000000;
  localparam int unsigned SETTLE_CYCLES = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [pks_pkg::CFG_IDX_W-1:0] cfg_index = pks_pkg::CFG_FILTER_ENABLE;
  logic [pks_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pks_sample_if sample_ch ();
  pks_pose_if pose_ch ();

  pose_kalman_smoother u_top (
    .clk(clk), .rst(rst), .sample(sample_ch.sink), .pose(pose_ch.source),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow of the block's registers and filter state.
  logic en_sh, vis_sh;
  logic [31:0] err_lim_sh;
  longint unsigned pos_r, ori_r, pos_q, ori_q;
  longint pos_est [3];
  quat4_t quat_est;
  longint unsigned pos_p, quat_p;
  bit seeded_sh;

  pks_pkg::sample_t pending_samples[$];
  pks_pkg::pose_t expected_poses[$];
  int unsigned cycles, fail_count, pose_count, sample_count, gated_count;
  bit no_idle;
  bit in_acc;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned gain_of(longint unsigned num, longint unsigned den);
    longint unsigned rem, quo;
    rem = num;
    quo = 0;
    if (den == 0) return 0;
    if (num >= den) return 64'd1 << 30;
    for (int i = 0; i < 30; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 1;
      end
    end
    return quo;
  endfunction

  // Predict, compute the gain, then shrink the variance by (1 - k).
  function automatic longint unsigned kalman_step(ref longint unsigned p,
                                                  input longint unsigned q,
                                                  input longint unsigned r);
    longint unsigned pp, k, f, hi, lo;
    pp = p + q;
    if (pp > VAR_MAX) pp = VAR_MAX;
    k = gain_of(pp, pp + r);
    f = (64'd1 << 30) - k;
    hi = (pp >> 24) * f;
    lo = (pp & 64'hFF_FFFF) * f;
    p = ((hi >> 6) + ((((hi & 64'd63) << 24) + lo) >> 30)) & VAR_MAX;
    return k;
  endfunction

  function automatic longint blend(longint x, longint z, longint unsigned k);
    longint d;
    longint unsigned m;
    d = z - x;
    m = ((d < 0 ? longint'(-d) : d) * k + (64'd1 << 29)) >> 30;
    return d < 0 ? x - longint'(m) : x + longint'(m);
  endfunction

  function automatic quat4_t normalize(quat4_t c);
    longint unsigned a [4];
    longint unsigned m, s, n, sq, v;
    bit tiny;
    int sh;
    quat4_t o;
    m = 0; s = 0; sq = 0; sh = 0; tiny = 1;
    for (int i = 0; i < 4; i++) begin
      a[i] = c[i] < 0 ? longint'(-c[i]) : c[i];
      if (a[i] > m) m = a[i];
      if (a[i] > 10) tiny = 0;
      else sq += a[i] * a[i];
    end
    // A near-zero quaternion collapses to the identity rotation.
    if (tiny && sq <= 115) begin
      o[0] = 0; o[1] = 0; o[2] = 0; o[3] = longint'(pks_pkg::QUAT_ONE);
      return o;
    end
    while ((m << sh) < (64'd1 << 29)) sh++;
    for (int i = 0; i < 4; i++) begin
      a[i] = a[i] << sh;
      s += (a[i] * a[i]) >> 2;
    end
    n = isqrt(s);
    for (int i = 0; i < 4; i++) begin
      v = ((a[i] << 29) + (n >> 1)) / n;
      o[i] = c[i] < 0 ? -longint'(v) : longint'(v);
    end
    return o;
  endfunction

  function automatic bit filter_pose(pks_pkg::sample_t s, output pks_pkg::pose_t r);
    longint zp [3];
    quat4_t zq, nq, tq;
    longint dot;
    longint unsigned k;
    r = '0;
    if (!en_sh) return 0;
    if (vis_sh && !s.seen) return 0;
    if (err_lim_sh != 0 && s.track_error > err_lim_sh) return 0;
    zp[0] = longint'(signed'(s.pos_x));
    zp[1] = longint'(signed'(s.pos_y));
    zp[2] = longint'(signed'(s.pos_z));
    zq[0] = longint'(signed'(s.quat_x));
    zq[1] = longint'(signed'(s.quat_y));
    zq[2] = longint'(signed'(s.quat_z));
    zq[3] = longint'(signed'(s.quat_w));
    if (!seeded_sh) begin
      for (int i = 0; i < 3; i++) pos_est[i] = zp[i];
      quat_est = normalize(zq);
      pos_p = pos_r;
      quat_p = ori_r;
      seeded_sh = 1;
    end
    k = kalman_step(pos_p, pos_q, pos_r);
    for (int i = 0; i < 3; i++) pos_est[i] = blend(pos_est[i], zp[i], k);
    k = kalman_step(quat_p, ori_q, ori_r);
    nq = normalize(zq);
    dot = 0;
    for (int i = 0; i < 4; i++) dot += quat_est[i] * nq[i];
    // Pick the hemisphere closest to the current estimate.
    if (dot < 0) for (int i = 0; i < 4; i++) nq[i] = -nq[i];
    for (int i = 0; i < 4; i++) tq[i] = blend(quat_est[i], nq[i], k);
    quat_est = normalize(tq);
    r.est_x = pos_est[0][31:0];
    r.est_y = pos_est[1][31:0];
    r.est_z = pos_est[2][31:0];
    r.est_qx = quat_est[0][31:0];
    r.est_qy = quat_est[1][31:0];
    r.est_qz = quat_est[2][31:0];
    r.est_qw = quat_est[3][31:0];
    r.out_error = s.track_error;
    r.out_seen = s.seen;
    r.out_port = s.port_tag;
    return 1;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $error("%s: expected %h, got %h", name, exp_v, act_v);
    end
  endfunction

  // Sample side: prediction and the sender.
  always @(posedge clk) begin
    pks_pkg::pose_t p;
    cycles <= cycles + 1;
    in_acc = !rst && sample_ch.valid && sample_ch.ready;
    if (in_acc) begin
      sample_count++;
      if (filter_pose(sample_ch.data, p)) expected_poses.push_back(p);
      else gated_count++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (!sample_ch.valid || in_acc) begin
      if (pending_samples.size() != 0 && (no_idle || $urandom_range(99) >= 37)) begin
        sample_ch.data <= pending_samples.pop_front();
        sample_ch.valid <= 1'b1;
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
    pose_ch.ready <= !rst && (no_idle || $urandom_range(99) >= 37);
  end

  // Pose side: compare each transaction with the oldest prediction.
  always @(posedge clk) begin
    pks_pkg::pose_t e;
    if (!rst && pose_ch.valid && pose_ch.ready) begin
      pose_count++;
      if (expected_poses.size() == 0) begin
        fail_count++;
        $error("pose transaction with no prediction pending");
      end else begin
        e = expected_poses.pop_front();
        check_field("est_x", e.est_x, pose_ch.data.est_x);
        check_field("est_y", e.est_y, pose_ch.data.est_y);
        check_field("est_z", e.est_z, pose_ch.data.est_z);
        check_field("est_qx", e.est_qx, pose_ch.data.est_qx);
        check_field("est_qy", e.est_qy, pose_ch.data.est_qy);
        check_field("est_qz", e.est_qz, pose_ch.data.est_qz);
        check_field("est_qw", e.est_qw, pose_ch.data.est_qw);
        check_field("out_error", e.out_error, pose_ch.data.out_error);
        check_field("out_seen", 32'(e.out_seen), 32'(pose_ch.data.out_seen));
        check_field("out_port", 32'(e.out_port), 32'(pose_ch.data.out_port));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d poses still pending", cycles,
               expected_poses.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [pks_pkg::CFG_IDX_W-1:0] idx, longint unsigned val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[47:0];
    case (idx)
      pks_pkg::CFG_FILTER_ENABLE:   en_sh = val[0];
      pks_pkg::CFG_NEED_VISIBLE:    vis_sh = val[0];
      pks_pkg::CFG_ERROR_LIMIT:     err_lim_sh = val[31:0];
      pks_pkg::CFG_POS_MEAS_VAR:    pos_r = val & VAR_MAX;
      pks_pkg::CFG_ORIENT_MEAS_VAR: ori_r = val & VAR_MAX;
      pks_pkg::CFG_POS_PROC_VAR:    pos_q = val & VAR_MAX;
      pks_pkg::CFG_ORIENT_PROC_VAR: ori_q = val & VAR_MAX;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !sample_ch.valid && expected_poses.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  function automatic pks_pkg::sample_t make_sample(bit clean);
    pks_pkg::sample_t s;
    int unsigned kind;
    s.pos_x = pick_word();
    s.pos_y = $urandom;
    s.pos_z = $urandom_range(3) == 0 ? pick_word() : 32'($signed($urandom_range(4000)) - 2000);
    kind = $urandom_range(9);
    if (kind == 0) begin
      // Tiny quaternion, always below the identity threshold.
      s.quat_x = 32'($signed($urandom_range(10)) - 5);
      s.quat_y = 32'($signed($urandom_range(10)) - 5);
      s.quat_z = 32'($signed($urandom_range(10)) - 5);
      s.quat_w = 32'($signed($urandom_range(10)) - 5);
    end else if (kind < 6) begin
      s.quat_x = 32'($signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
      s.quat_y = 32'($signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
      s.quat_z = 32'($signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
      s.quat_w = $urandom_range(1) ? 32'h3800_0000 : 32'hC800_0000;
    end else begin
      s.quat_x = pick_word();
      s.quat_y = $urandom;
      s.quat_z = $urandom;
      s.quat_w = pick_word();
    end
    s.port_tag = $urandom;
    if (clean) begin
      s.seen = 1'b1;
      s.track_error = $urandom_range(err_lim_sh == 0 ? 32'hFFFF_FFFF : err_lim_sh);
    end else begin
      s.seen = $urandom_range(1);
      s.track_error = $urandom_range(1) ? $urandom : $urandom_range(400000);
    end
    return s;
  endfunction

  function automatic pks_pkg::sample_t fixed_sample(logic [31:0] px, logic [31:0] qx,
                                                    logic [31:0] qw, logic [31:0] er,
                                                    logic vis);
    pks_pkg::sample_t s;
    s = '{pos_x: px, pos_y: ~px, pos_z: 32'd0, quat_x: qx, quat_y: 32'd0, quat_z: 32'd0,
          quat_w: qw, track_error: er, seen: vis, port_tag: px[7:0] ^ 8'hA5};
    return s;
  endfunction

  initial begin
    pks_pkg::sample_t s;
    sample_ch.valid = 1'b0;
    sample_ch.data = '0;
    pose_ch.ready = 1'b0;
    cycles = 0; fail_count = 0; pose_count = 0; sample_count = 0; gated_count = 0;
    no_idle = 0;
    en_sh = 1; vis_sh = 1; err_lim_sh = pks_pkg::RST_ERROR_LIMIT;
    pos_r = pks_pkg::RST_POS_MEAS_VAR; ori_r = pks_pkg::RST_ORIENT_MEAS_VAR;
    pos_q = pks_pkg::RST_POS_PROC_VAR; ori_q = pks_pkg::RST_ORIENT_PROC_VAR;
    for (int i = 0; i < 3; i++) pos_est[i] = 0;
    for (int i = 0; i < 4; i++) quat_est[i] = 0;
    pos_p = 0; quat_p = 0; seeded_sh = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: gate edges, seeding, extremes and the hemisphere flip.
    pending_samples.push_back(fixed_sample(32'd5, 32'd0, 32'd0, 32'd0, 1'b0));
    pending_samples.push_back(fixed_sample(32'd7, 32'd0, 32'h4000_0000, 32'd327681, 1'b1));
    pending_samples.push_back(fixed_sample(32'h0001_0000, 32'd3, 32'd4, 32'd327680, 1'b1));
    pending_samples.push_back(fixed_sample(32'h7FFF_FFFF, 32'd0, 32'h4000_0000, 32'd0, 1'b1));
    pending_samples.push_back(fixed_sample(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd1, 1'b1));
    pending_samples.push_back(fixed_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           32'd100, 1'b1));
    pending_samples.push_back(fixed_sample(32'd0, 32'd0, 32'hC000_0000, 32'd0, 1'b1));
    pending_samples.push_back(fixed_sample(32'd0, 32'd11, 32'd0, 32'd0, 1'b1));
    pending_samples.push_back(fixed_sample(32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'd0, 1'b1));
    pending_samples.push_back(fixed_sample(32'd12, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1));
    drain();
    write_reg(pks_pkg::CFG_NEED_VISIBLE, 0);
    write_reg(pks_pkg::CFG_ERROR_LIMIT, 0);
    end_writes();
    pending_samples.push_back(fixed_sample(32'd99, 32'd5, 32'd5, 32'hFFFF_FFFF, 1'b0));
    pending_samples.push_back(fixed_sample(32'd98, 32'h4000_0000, 32'd0, 32'd3, 1'b1));
    drain();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(pks_pkg::CFG_NEED_VISIBLE, 1);
          write_reg(pks_pkg::CFG_ERROR_LIMIT, pks_pkg::RST_ERROR_LIMIT);
        end
        1: begin
          write_reg(pks_pkg::CFG_POS_MEAS_VAR, 1);
          write_reg(pks_pkg::CFG_ORIENT_MEAS_VAR, 1);
          write_reg(pks_pkg::CFG_POS_PROC_VAR, 1);
          write_reg(pks_pkg::CFG_ORIENT_PROC_VAR, 1);
        end
        2: begin
          // Largest variances drive the predicted variance into saturation.
          write_reg(pks_pkg::CFG_POS_MEAS_VAR, VAR_MAX);
          write_reg(pks_pkg::CFG_ORIENT_MEAS_VAR, VAR_MAX);
          write_reg(pks_pkg::CFG_POS_PROC_VAR, VAR_MAX);
          write_reg(pks_pkg::CFG_ORIENT_PROC_VAR, VAR_MAX);
        end
        3: begin
          write_reg(pks_pkg::CFG_ERROR_LIMIT, 32'hFFFF_FFFF);
          write_reg(pks_pkg::CFG_NEED_VISIBLE, 0);
          write_reg(pks_pkg::CFG_POS_PROC_VAR, 1);
          write_reg(pks_pkg::CFG_ORIENT_MEAS_VAR, {$urandom, $urandom} & VAR_MAX | 1);
        end
        4: begin
          write_reg(pks_pkg::CFG_FILTER_ENABLE, 0);
          write_reg(3'd7, 64'h1234);
        end
        5: begin
          write_reg(pks_pkg::CFG_FILTER_ENABLE, 1);
          write_reg(pks_pkg::CFG_NEED_VISIBLE, 1);
          write_reg(pks_pkg::CFG_ERROR_LIMIT, 200000 + $urandom_range(200000));
          write_reg(pks_pkg::CFG_POS_MEAS_VAR, 64'(($urandom | 1)) << 4);
          write_reg(pks_pkg::CFG_ORIENT_PROC_VAR, 64'($urandom_range(1 << 24)) + 1);
          no_idle = 1;
        end
        6: begin
          write_reg(pks_pkg::CFG_ERROR_LIMIT, 0);
          write_reg(pks_pkg::CFG_POS_PROC_VAR, {$urandom, $urandom} & VAR_MAX | 1);
          no_idle = 0;
        end
        default: begin
          write_reg(pks_pkg::CFG_NEED_VISIBLE, 1);
          write_reg(pks_pkg::CFG_ERROR_LIMIT, pks_pkg::RST_ERROR_LIMIT);
          write_reg(pks_pkg::CFG_POS_MEAS_VAR, pks_pkg::RST_POS_MEAS_VAR);
          write_reg(pks_pkg::CFG_ORIENT_MEAS_VAR, pks_pkg::RST_ORIENT_MEAS_VAR);
          write_reg(pks_pkg::CFG_POS_PROC_VAR, pks_pkg::RST_POS_PROC_VAR);
          write_reg(pks_pkg::CFG_ORIENT_PROC_VAR, pks_pkg::RST_ORIENT_PROC_VAR);
        end
      endcase
      end_writes();
      for (int n = 0; n < (ph == 4 ? 30 : 180); n++) begin
        s = make_sample($urandom_range(99) < 80);
        pending_samples.push_back(s);
      end
      drain();
    end

    $display("covered %0d samples, %0d poses checked, %0d gated out, eight register settings",
             sample_count, pose_count, gated_count);
    if (fail_count == 0 && expected_poses.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches, %0d poses never arrived", fail_count, expected_poses.size());
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
